[hw/rtl/fvc_pkg.sv]
package fvc_pkg;

    // Input format and phase resolution.
    localparam int IN_FRAC_BITS = 12;
    localparam int DATA_W       = 16;
    localparam int PH_BITS      = 24;

    // Angle unit: one rotation stage per CORDIC step.
    localparam int CORDIC_STEPS = 22;
    localparam int CW           = 36;   // x/y datapath, inputs scaled by 2^16
    localparam int ZW           = 25;   // accumulated angle, signed

    // Wheel geometry.
    localparam int RY    = 15;
    localparam int YG    = 6;
    localparam int GC    = 4;
    localparam int CB    = 11;
    localparam int BM    = 13;
    localparam int MR    = 6;
    localparam int NCOLS = RY + YG + GC + CB + BM + MR;
    localparam int K_W   = 6;

    // Length unit: one result bit per stage.
    localparam int RAD_W     = 17;
    localparam int SQN_W     = 33;
    localparam int ISQ_STEPS = 17;

    // Both front units line up at this latency.
    localparam int PIPE_LAT = CORDIC_STEPS + 2;
    localparam int ISQ_PAD  = PIPE_LAT - ISQ_STEPS - 2;

    localparam logic [21:0] ATAN_TURNS [CORDIC_STEPS] = '{
        22'd2097152, 22'd1238021, 22'd654136, 22'd332050, 22'd166669, 22'd83416,
        22'd41718, 22'd20860, 22'd10430, 22'd5215, 22'd2608, 22'd1304, 22'd652,
        22'd326, 22'd163, 22'd81, 22'd41, 22'd20, 22'd10, 22'd5, 22'd3, 22'd1
    };

    // Ramps of the wheel segments, floor(255 * i / segment length).
    localparam logic [7:0] YG_RAMP [YG] = '{8'd0, 8'd42, 8'd85, 8'd127, 8'd170, 8'd212};
    localparam logic [7:0] GC_RAMP [GC] = '{8'd0, 8'd63, 8'd127, 8'd191};
    localparam logic [7:0] CB_RAMP [CB] = '{
        8'd0, 8'd23, 8'd46, 8'd69, 8'd92, 8'd115, 8'd139, 8'd162, 8'd185, 8'd208, 8'd231
    };
    localparam logic [7:0] BM_RAMP [BM] = '{
        8'd0, 8'd19, 8'd39, 8'd58, 8'd78, 8'd98, 8'd117, 8'd137, 8'd156, 8'd176,
        8'd196, 8'd215, 8'd235
    };
    localparam logic [7:0] MR_RAMP [MR] = '{8'd0, 8'd42, 8'd85, 8'd127, 8'd170, 8'd212};

    typedef struct packed {
        logic signed [DATA_W-1:0] flow_x;
        logic signed [DATA_W-1:0] flow_y;
        logic                     flow_valid;
    } t_flow_req;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_flow_rgb;

    function automatic t_flow_rgb wheel_entry(input logic [K_W-1:0] k);
        t_flow_rgb c;
        logic [K_W-1:0] i;
        c = '0;
        i = '0;
        if (k < K_W'(RY)) begin
            i = k;
            c.red   = 8'd255;
            c.green = 8'(i) * 8'd17;
        end else if (k < K_W'(RY + YG)) begin
            i = k - K_W'(RY);
            c.red   = 8'd255 - YG_RAMP[i[2:0]];
            c.green = 8'd255;
        end else if (k < K_W'(RY + YG + GC)) begin
            i = k - K_W'(RY + YG);
            c.green = 8'd255;
            c.blue  = GC_RAMP[i[1:0]];
        end else if (k < K_W'(RY + YG + GC + CB)) begin
            i = k - K_W'(RY + YG + GC);
            c.green = 8'd255 - CB_RAMP[i[3:0]];
            c.blue  = 8'd255;
        end else if (k < K_W'(RY + YG + GC + CB + BM)) begin
            i = k - K_W'(RY + YG + GC + CB);
            c.red  = BM_RAMP[i[3:0]];
            c.blue = 8'd255;
        end else begin
            i = k - K_W'(RY + YG + GC + CB + BM);
            if (i >= K_W'(MR)) begin
                i = i - K_W'(MR);
            end
            c.red  = 8'd255;
            c.blue = 8'd255 - MR_RAMP[i[2:0]];
        end
        return c;
    endfunction

endpackage

[hw/rtl/fvc_cordic.sv]
module fvc_cordic (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic                               i_valid,
    input  logic signed [fvc_pkg::DATA_W-1:0]  i_fx,
    input  logic signed [fvc_pkg::DATA_W-1:0]  i_fy,
    output logic                               o_valid,
    output logic [fvc_pkg::K_W-1:0]            o_k0,
    output logic [fvc_pkg::PH_BITS-1:0]        o_frac
);

    localparam int CW    = fvc_pkg::CW;
    localparam int ZW    = fvc_pkg::ZW;
    localparam int STEPS = fvc_pkg::CORDIC_STEPS;
    localparam int PB    = fvc_pkg::PH_BITS;
    localparam int MW    = PB + fvc_pkg::K_W;

    typedef struct packed {
        logic half;
        logic fy_pos;
        logic fy_neg;
        logic y_zero;
    } t_flags;

    logic signed [CW-1:0] r_x  [STEPS+1];
    logic signed [CW-1:0] r_y  [STEPS+1];
    logic signed [ZW-1:0] r_z  [STEPS+1];
    t_flags               r_fl [STEPS+1];
    logic                 r_v  [STEPS+1];

    // Left half plane vectors are turned by a half turn first.
    logic signed [fvc_pkg::DATA_W:0] n_sx, n_sy, n_ax, n_ay;
    t_flags n_fl;

    assign n_sx = (fvc_pkg::DATA_W+1)'(i_fx);
    assign n_sy = (fvc_pkg::DATA_W+1)'(i_fy);
    assign n_ax = i_fx[fvc_pkg::DATA_W-1] ? -n_sx : n_sx;
    assign n_ay = i_fx[fvc_pkg::DATA_W-1] ? -n_sy : n_sy;
    assign n_fl.half   = i_fx[fvc_pkg::DATA_W-1];
    assign n_fl.fy_pos = !i_fy[fvc_pkg::DATA_W-1] && (i_fy != '0);
    assign n_fl.fy_neg = i_fy[fvc_pkg::DATA_W-1];
    assign n_fl.y_zero = (i_fy == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]  <= {{(CW-fvc_pkg::DATA_W-17){n_ax[fvc_pkg::DATA_W]}}, n_ax, 16'b0};
            r_y[0]  <= {{(CW-fvc_pkg::DATA_W-17){n_ay[fvc_pkg::DATA_W]}}, n_ay, 16'b0};
            r_z[0]  <= '0;
            r_fl[0] <= n_fl;
        end
    end

    for (genvar g = 0; g < STEPS; g++) begin : g_step
        logic signed [CW-1:0] w_dx, w_dy;
        logic signed [ZW-1:0] w_at;

        assign w_dx = r_y[g] >>> g;
        assign w_dy = r_x[g] >>> g;
        assign w_at = ZW'(fvc_pkg::ATAN_TURNS[g]);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g+1] <= 1'b0;
            end else if (i_en) begin
                r_v[g+1] <= r_v[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_fl[g+1] <= r_fl[g];
                if (r_y[g] > 0) begin
                    r_x[g+1] <= r_x[g] + w_dx;
                    r_y[g+1] <= r_y[g] - w_dy;
                    r_z[g+1] <= r_z[g] + w_at;
                end else begin
                    r_x[g+1] <= r_x[g] - w_dx;
                    r_y[g+1] <= r_y[g] + w_dy;
                    r_z[g+1] <= r_z[g] - w_at;
                end
            end
        end
    end

    // Zero the angle when y is zero; keep small right half plane angles on their own side of the seam.
    logic signed [ZW-1:0] n_zc;
    logic [PB-1:0]        n_ph;
    logic [MW-1:0]        n_m;
    t_flags               w_fl;

    assign w_fl = r_fl[STEPS];

    always_comb begin
        n_zc = r_z[STEPS];
        if (w_fl.y_zero) begin
            n_zc = '0;
        end else if (!w_fl.half && w_fl.fy_pos && r_z[STEPS][ZW-1]) begin
            n_zc = '0;
        end else if (!w_fl.half && w_fl.fy_neg && !r_z[STEPS][ZW-1]) begin
            n_zc = '1;
        end
    end

    assign n_ph = {w_fl.half, {(PB-1){1'b0}}} + n_zc[PB-1:0];
    assign n_m  = MW'(n_ph) * MW'(fvc_pkg::NCOLS - 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r_v[STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_k0   <= n_m[MW-1:PB];
            o_frac <= n_m[PB-1:0];
        end
    end

endmodule

[hw/rtl/fvc_isqrt.sv]
module fvc_isqrt (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic                               i_flow_valid,
    input  logic signed [fvc_pkg::DATA_W-1:0]  i_fx,
    input  logic signed [fvc_pkg::DATA_W-1:0]  i_fy,
    output logic [fvc_pkg::RAD_W-1:0]          o_rad,
    output logic                               o_inside,
    output logic                               o_flow_valid
);

    localparam int NW    = fvc_pkg::SQN_W;
    localparam int RW    = NW + 1;
    localparam int STEPS = fvc_pkg::ISQ_STEPS;
    localparam int PAD   = fvc_pkg::ISQ_PAD;
    localparam int SH    = 32 - 2 * fvc_pkg::IN_FRAC_BITS;
    localparam logic [31:0] UNIT_SQ = 32'd1 << (2 * fvc_pkg::IN_FRAC_BITS);

    logic signed [31:0] w_px, w_py;
    logic [30:0]        r_sqx, r_sqy;
    logic               r_fv0;
    logic [31:0]        n_sum;
    logic               n_in;

    assign w_px  = i_fx * i_fx;
    assign w_py  = i_fy * i_fy;
    assign n_sum = {1'b0, r_sqx} + {1'b0, r_sqy};
    assign n_in  = (n_sum <= UNIT_SQ);

    logic [NW-1:0] r_n  [STEPS+1];
    logic [RW-1:0] r_r  [STEPS+1];
    logic          r_in [STEPS+1];
    logic          r_fv [STEPS+1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sqx <= w_px[30:0];
            r_sqy <= w_py[30:0];
            r_fv0 <= i_flow_valid;
            // The length is only used inside the unit disc.
            r_n[0]  <= n_in ? (NW'(n_sum) << SH) : '0;
            r_r[0]  <= '0;
            r_in[0] <= n_in;
            r_fv[0] <= r_fv0;
        end
    end

    for (genvar g = 0; g < STEPS; g++) begin : g_bit
        localparam logic [RW-1:0] BIT = RW'(1) << (2 * (STEPS - 1 - g));
        logic [RW:0] w_t;

        assign w_t = (RW+1)'(r_r[g]) + (RW+1)'(BIT);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_in[g+1] <= r_in[g];
                r_fv[g+1] <= r_fv[g];
                if ((RW+1)'(r_n[g]) >= w_t) begin
                    r_n[g+1] <= r_n[g] - w_t[NW-1:0];
                    r_r[g+1] <= (r_r[g] >> 1) + BIT;
                end else begin
                    r_n[g+1] <= r_n[g];
                    r_r[g+1] <= r_r[g] >> 1;
                end
            end
        end
    end

    // Delay line that matches the angle unit's latency.
    logic [fvc_pkg::RAD_W-1:0] r_pad_rad [PAD];
    logic                      r_pad_in  [PAD];
    logic                      r_pad_fv  [PAD];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pad_rad[0] <= r_r[STEPS][fvc_pkg::RAD_W-1:0];
            r_pad_in[0]  <= r_in[STEPS];
            r_pad_fv[0]  <= r_fv[STEPS];
        end
    end

    for (genvar p = 1; p < PAD; p++) begin : g_pad
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_pad_rad[p] <= r_pad_rad[p-1];
                r_pad_in[p]  <= r_pad_in[p-1];
                r_pad_fv[p]  <= r_pad_fv[p-1];
            end
        end
    end

    assign o_rad        = r_pad_rad[PAD-1];
    assign o_inside     = r_pad_in[PAD-1];
    assign o_flow_valid = r_pad_fv[PAD-1];

endmodule

[hw/rtl/fvc_blend.sv]
module fvc_blend (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic [fvc_pkg::K_W-1:0]      i_k0,
    input  logic [fvc_pkg::PH_BITS-1:0]  i_frac,
    input  logic [fvc_pkg::RAD_W-1:0]    i_rad,
    input  logic                         i_inside,
    input  logic                         i_flow_valid,
    output logic                         o_valid,
    output fvc_pkg::t_flow_rgb           o_rgb
);

    localparam int PB = fvc_pkg::PH_BITS;
    localparam int RW = fvc_pkg::RAD_W;
    localparam int PW = RW + 32;
    localparam logic [31:0]   FULL_C = 32'd255 << PB;
    localparam logic [PW-1:0] WHITE  = PW'(255) << 40;

    fvc_pkg::t_flow_rgb w_e0, w_e1, n_rgb;
    logic [7:0]    w_c0 [3];
    logic [7:0]    w_c1 [3];
    logic [PB:0]   w_inv;

    assign w_e0  = fvc_pkg::wheel_entry(i_k0);
    assign w_e1  = fvc_pkg::wheel_entry(i_k0 + fvc_pkg::K_W'(1));
    assign w_c0[0] = w_e0.red;
    assign w_c0[1] = w_e0.green;
    assign w_c0[2] = w_e0.blue;
    assign w_c1[0] = w_e1.red;
    assign w_c1[1] = w_e1.green;
    assign w_c1[2] = w_e1.blue;
    assign w_inv = (PB+1)'(1) << PB;

    logic [PB+8:0]  r_a_p0 [3];
    logic [PB+7:0]  r_a_p1 [3];
    logic [31:0]    r_b_c  [3];
    logic [31:0]    r_b_d  [3];
    logic [PW-1:0]  r_c_pr [3];
    logic [33:0]    r_c_c3 [3];
    logic [7:0]     n_ch   [3];

    logic          r_a_v, r_b_v, r_c_v;
    logic          r_a_fv, r_b_fv, r_c_fv;
    logic          r_a_in, r_b_in, r_c_in;
    logic [RW-1:0] r_a_rad, r_b_rad;

    for (genvar c = 0; c < 3; c++) begin : g_ch
        logic [31:0]   w_sum;
        logic [PW-1:0] w_diff;

        assign w_sum  = 32'(r_a_p0[c] + (PB+9)'(r_a_p1[c]));
        assign w_diff = WHITE - r_c_pr[c];
        assign n_ch[c] = !r_c_fv ? 8'd0 : (r_c_in ? w_diff[47:40] : r_c_c3[c][33:26]);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_a_p0[c] <= (PB+9)'(w_inv - (PB+1)'(i_frac)) * (PB+9)'(w_c0[c]);
                r_a_p1[c] <= (PB+8)'(i_frac) * (PB+8)'(w_c1[c]);
                r_b_c[c]  <= w_sum;
                r_b_d[c]  <= FULL_C - w_sum;
                r_c_pr[c] <= PW'(r_b_rad) * PW'(r_b_d[c]);
                r_c_c3[c] <= 34'(r_b_c[c]) * 34'd3;
            end
        end
    end

    assign n_rgb.red   = n_ch[0];
    assign n_rgb.green = n_ch[1];
    assign n_rgb.blue  = n_ch[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v   <= 1'b0;
            r_b_v   <= 1'b0;
            r_c_v   <= 1'b0;
            o_valid <= 1'b0;
        end else if (i_en) begin
            r_a_v   <= i_valid;
            r_b_v   <= r_a_v;
            r_c_v   <= r_b_v;
            o_valid <= r_c_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_fv  <= i_flow_valid;
            r_a_in  <= i_inside;
            r_a_rad <= i_rad;
            r_b_fv  <= r_a_fv;
            r_b_in  <= r_a_in;
            r_b_rad <= r_a_rad;
            r_c_fv  <= r_b_fv;
            r_c_in  <= r_b_in;
            o_rgb   <= n_rgb;
        end
    end

endmodule

[hw/rtl/flow_vector_to_color.sv]
// Channel   Direction  Signals                                      Payload
// request   in         i_in_valid, o_in_ready, i_in_req             flow_x, flow_y, flow_valid
// response  out        o_out_valid, i_out_ready, o_out_rsp          red, green, blue
//
// One request enters per clock while the skid register is empty. Its response passes
// through the input register, the 22-stage CORDIC angle unit with its own entry and
// exit stages, four stages of wheel blend and shading, and the output register.
// Reset is synchronous and active low; it clears all valid bits, no data registers.
// A stalled response parks the next one in a skid register, and the whole pipeline
// then holds in place until the skid register drains.
module flow_vector_to_color (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  fvc_pkg::t_flow_req i_in_req,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output fvc_pkg::t_flow_rgb o_out_rsp
);

    // The pipeline advances whenever the skid register is empty. This is a
    // registered signal, so no ready path runs through the stages.
    logic en;
    logic r_skid_valid;
    logic r_out_valid;
    fvc_pkg::t_flow_rgb r_skid, r_out;

    assign en         = !r_skid_valid;
    assign o_in_ready = en;

    // Entry register for the request.
    logic               r_in_valid;
    fvc_pkg::t_flow_req r_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (en) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_in <= i_in_req;
        end
    end

    // Angle unit: wheel index and blend fraction.
    logic                         ang_valid;
    logic [fvc_pkg::K_W-1:0]      ang_k0;
    logic [fvc_pkg::PH_BITS-1:0]  ang_frac;

    fvc_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_in_valid),
        .i_fx    (r_in.flow_x),
        .i_fy    (r_in.flow_y),
        .o_valid (ang_valid),
        .o_k0    (ang_k0),
        .o_frac  (ang_frac)
    );

    // Length unit: radius and the unit disc test, aligned to the angle unit.
    logic [fvc_pkg::RAD_W-1:0] len_rad;
    logic                      len_inside;
    logic                      len_fv;

    fvc_isqrt u_isqrt (
        .i_clk        (i_clk),
        .i_en         (en),
        .i_flow_valid (r_in.flow_valid),
        .i_fx         (r_in.flow_x),
        .i_fy         (r_in.flow_y),
        .o_rad        (len_rad),
        .o_inside     (len_inside),
        .o_flow_valid (len_fv)
    );

    // Wheel lookup, interpolation and saturation shading.
    logic               bl_valid;
    fvc_pkg::t_flow_rgb bl_rgb;

    fvc_blend u_blend (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (en),
        .i_valid      (ang_valid),
        .i_k0         (ang_k0),
        .i_frac       (ang_frac),
        .i_rad        (len_rad),
        .i_inside     (len_inside),
        .i_flow_valid (len_fv),
        .o_valid      (bl_valid),
        .o_rgb        (bl_rgb)
    );

    // Output register with a skid register behind it. A response that leaves
    // the pipeline while the output is stalled lands in the skid register.
    logic push;
    assign push = en && bl_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (i_out_ready || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= push;
            end
        end else if (push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_out_ready || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else begin
                r_out <= bl_rgb;
            end
        end else if (push) begin
            r_skid <= bl_rgb;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out;

    // The skid register is only ever filled behind a waiting response.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register holds a response while the output is empty");

    a_skid_fill_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && !i_out_ready))
        else $error("skid register filled without an output stall");

    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && i_out_ready) |=> !r_skid_valid)
        else $error("skid register did not drain when the output was taken");

endmodule

[dv/flow_vector_to_color_test.sv]
`timescale 1ns / 1ps

module flow_vector_to_color_test;

    localparam int N_RANDOM  = 1300;
    localparam int WDOG_MAX  = 5000;
    localparam int DRAIN_CYC = 40;

    // Angle table of the CORDIC, in units of 2^-24 turn.
    localparam longint ANGLE_STEP [22] = '{
        2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860,
        10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1
    };

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    fvc_pkg::t_flow_req i_in_req;
    logic               o_out_valid;
    logic               i_out_ready;
    fvc_pkg::t_flow_rgb o_out_rsp;

    flow_vector_to_color u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_req   (i_in_req),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_rsp  (o_out_rsp)
    );

    // The clock runs with a 2 ns period.
    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // Expected colors, oldest first, one per accepted request.
    fvc_pkg::t_flow_rgb pending_colors[$];
    int        n_mismatch;
    int        n_checked;
    int        idle_calm;   // nonzero while both sides run without idling
    int        wdog;

    // Floor of the square root of a 64-bit value, one result bit per pass.
    function automatic longint unsigned root_floor(input longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Floor division by a power of two, also for negative values.
    function automatic longint shift_floor(input longint v, input int s);
        if (v >= 0) return v >>> s;
        return -(((-v) - 1) >>> s) - 1;
    endfunction

    // Direction of the vector in 2^-24 turns, counterclockwise from +x.
    function automatic longint unsigned flow_angle(input longint fx, input longint fy);
        longint x;
        longint y;
        longint z;
        longint base;
        longint dx;
        longint dy;
        bit     right_half;
        x = fx;
        y = fy;
        z = 0;
        base = 0;
        if (x < 0) begin
            x = -x;
            y = -y;
            base = 64'd1 << 23;
        end
        right_half = (base == 0);
        if (y != 0) begin
            x = x * 65536;
            y = y * 65536;
            for (int i = 0; i < 22; i++) begin
                dx = shift_floor(y, i);
                dy = shift_floor(x, i);
                if (y > 0) begin
                    x = x + dx;
                    y = y - dy;
                    z = z + ANGLE_STEP[i];
                end else begin
                    x = x - dx;
                    y = y + dy;
                    z = z - ANGLE_STEP[i];
                end
            end
            // Keep small angles on their own side of the wheel seam.
            if (right_half && fy > 0 && z < 0) z = 0;
            if (right_half && fy < 0 && z > -1) z = -1;
        end
        return longint'(base + z) & ((64'd1 << 24) - 1);
    endfunction

    // One wheel entry as three 0..255 channel values.
    function automatic void wheel_color(input int k, output longint unsigned c[3]);
        int i;
        if (k < fvc_pkg::RY) begin
            c = '{255, 255 * k / fvc_pkg::RY, 0};
        end else if (k < fvc_pkg::RY + fvc_pkg::YG) begin
            i = k - fvc_pkg::RY;
            c = '{255 - 255 * i / fvc_pkg::YG, 255, 0};
        end else if (k < fvc_pkg::RY + fvc_pkg::YG + fvc_pkg::GC) begin
            i = k - fvc_pkg::RY - fvc_pkg::YG;
            c = '{0, 255, 255 * i / fvc_pkg::GC};
        end else if (k < fvc_pkg::RY + fvc_pkg::YG + fvc_pkg::GC + fvc_pkg::CB) begin
            i = k - fvc_pkg::RY - fvc_pkg::YG - fvc_pkg::GC;
            c = '{0, 255 - 255 * i / fvc_pkg::CB, 255};
        end else if (k < fvc_pkg::NCOLS - fvc_pkg::MR) begin
            i = k - fvc_pkg::RY - fvc_pkg::YG - fvc_pkg::GC - fvc_pkg::CB;
            c = '{255 * i / fvc_pkg::BM, 0, 255};
        end else begin
            i = (k - (fvc_pkg::NCOLS - fvc_pkg::MR)) % fvc_pkg::MR;
            c = '{255, 0, 255 - 255 * i / fvc_pkg::MR};
        end
    endfunction

    // Color of one flow request.
    function automatic fvc_pkg::t_flow_rgb flow_color(input fvc_pkg::t_flow_req r);
        longint             fx;
        longint             fy;
        longint unsigned    sq;
        longint unsigned    rad;
        longint unsigned    m;
        longint unsigned    frac;
        longint unsigned    c;
        longint unsigned    v;
        longint unsigned    w0[3];
        longint unsigned    w1[3];
        longint unsigned    ch[3];
        bit                 in_disc;
        int                 k0;
        fvc_pkg::t_flow_rgb res;
        fx = longint'(r.flow_x);
        fy = longint'(r.flow_y);
        if (!r.flow_valid) return '0;
        sq = longint'(fx * fx) + longint'(fy * fy);
        in_disc = (sq <= (64'd1 << (2 * fvc_pkg::IN_FRAC_BITS)));
        rad = root_floor(sq << (32 - 2 * fvc_pkg::IN_FRAC_BITS));
        m = longint'(fvc_pkg::NCOLS - 1) * flow_angle(fx, fy);
        k0 = int'(m >> 24);
        if (k0 > fvc_pkg::NCOLS - 1) k0 = fvc_pkg::NCOLS - 1;
        frac = m & ((64'd1 << 24) - 1);
        wheel_color(k0, w0);
        wheel_color((k0 + 1) % fvc_pkg::NCOLS, w1);
        for (int b = 0; b < 3; b++) begin
            c = ((64'd1 << 24) - frac) * w0[b] + frac * w1[b];
            if (in_disc) begin
                v = ((64'd255 << 40) - rad * ((64'd255 << 24) - c)) >> 40;
            end else begin
                v = (3 * c) >> 26;
            end
            ch[b] = v & 8'hFF;
        end
        res.red   = ch[0][7:0];
        res.green = ch[1][7:0];
        res.blue  = ch[2][7:0];
        return res;
    endfunction

    // Returns 1 with a chance of about 35 in 100, unless a calm stretch is running.
    function automatic bit idle_now();
        if (idle_calm != 0) return 1'b0;
        return ($urandom_range(99) < 35);
    endfunction

    // Directed rows. A row with has_gold set carries its color typed in;
    // the others are checked against the predictor only.
    typedef struct {
        fvc_pkg::t_flow_req req;
        bit                 has_gold;
        fvc_pkg::t_flow_rgb gold;
    } t_flow_row;

    localparam int N_ROWS = 22;
    t_flow_row rows [N_ROWS];

    initial begin
        // Invalid vectors give black, whatever the vector is.
        rows[0]  = '{'{16'sh7FFF, 16'sh7FFF, 1'b0}, 1, '{8'd0, 8'd0, 8'd0}};
        rows[1]  = '{'{-16'sh8000, 16'sh1234, 1'b0}, 1, '{8'd0, 8'd0, 8'd0}};
        // The zero vector is white.
        rows[2]  = '{'{16'sh0000, 16'sh0000, 1'b1}, 1, '{8'd255, 8'd255, 8'd255}};
        // Long vector on +x: pure red scaled by three quarters.
        rows[3]  = '{'{16'sh7FFF, 16'sh0000, 1'b1}, 1, '{8'd191, 8'd0, 8'd0}};
        // Unit length on +x: fully saturated red.
        rows[4]  = '{'{16'sh1000, 16'sh0000, 1'b1}, 1, '{8'd255, 8'd0, 8'd0}};
        // The negative x axis lands on a half turn.
        rows[5]  = '{'{-16'sh8000, 16'sh0000, 1'b1}, 0, '0};
        rows[6]  = '{'{-16'sh1000, 16'sh0000, 1'b1}, 0, '0};
        // Both axes of y and three corners of the range.
        rows[7]  = '{'{16'sh0000, 16'sh7FFF, 1'b1}, 0, '0};
        rows[8]  = '{'{16'sh0000, -16'sh8000, 1'b1}, 0, '0};
        rows[9]  = '{'{-16'sh8000, -16'sh8000, 1'b1}, 0, '0};
        rows[10] = '{'{16'sh7FFF, -16'sh8000, 1'b1}, 0, '0};
        rows[11] = '{'{-16'sh8000, 16'sh7FFF, 1'b1}, 0, '0};
        // Small angles either side of the seam.
        rows[12] = '{'{16'sh7FFF, 16'sh0001, 1'b1}, 0, '0};
        rows[13] = '{'{16'sh7FFF, -16'sh0001, 1'b1}, 0, '0};
        rows[14] = '{'{16'sh0001, -16'sh0001, 1'b1}, 0, '0};
        rows[15] = '{'{-16'sh0001, 16'sh0001, 1'b1}, 0, '0};
        // Just inside and just outside the unit disc.
        rows[16] = '{'{16'sh0B50, 16'sh0B50, 1'b1}, 0, '0};
        rows[17] = '{'{16'sh0B51, 16'sh0B51, 1'b1}, 0, '0};
        rows[18] = '{'{16'sh0000, 16'sh1000, 1'b1}, 0, '0};
        rows[19] = '{'{16'sh0000, 16'sh1001, 1'b1}, 0, '0};
        rows[20] = '{'{16'sh0001, 16'sh0000, 1'b1}, 0, '0};
        rows[21] = '{'{-16'sh0800, -16'sh0400, 1'b1}, 0, '0};
    end

    // Random request: mostly vectors near the unit disc, some full range.
    function automatic fvc_pkg::t_flow_req random_flow();
        fvc_pkg::t_flow_req r;
        int                 sel;
        sel = $urandom_range(9);
        r.flow_valid = ($urandom_range(9) != 0);
        if (sel < 6) begin
            r.flow_x = 16'($signed($urandom_range(12288)) - 6144);
            r.flow_y = 16'($signed($urandom_range(12288)) - 6144);
        end else if (sel < 8) begin
            r.flow_x = 16'($urandom);
            r.flow_y = 16'($urandom);
        end else begin
            // Near an axis, where the angle is most delicate.
            r.flow_x = 16'($urandom);
            r.flow_y = 16'($signed($urandom_range(6)) - 3);
            if ($urandom_range(1) != 0) begin
                r.flow_y = r.flow_x;
                r.flow_x = 16'($signed($urandom_range(6)) - 3);
            end
        end
        return r;
    endfunction

    // Put one request on the input channel and wait until it is taken.
    // Valid drops only in the idle cycles before the next request.
    task automatic send_flow(input fvc_pkg::t_flow_req r, input bit has_gold,
                             input fvc_pkg::t_flow_rgb gold);
        fvc_pkg::t_flow_rgb want;
        while (idle_now()) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req   <= r;
        do @(posedge i_clk); while (!o_in_ready);
        want = flow_color(r);
        if (has_gold && want != gold) begin
            $display("table row disagrees with the predictor for %h", r);
        end
        pending_colors.insert(pending_colors.size(), has_gold ? gold : want);
    endtask

    // Response side: random back pressure, checking at each accepted color.
    always @(posedge i_clk) begin
        fvc_pkg::t_flow_rgb want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (pending_colors.size() == 0) begin
                    n_mismatch++;
                    if (n_mismatch <= 10) begin
                        $display("unexpected color %h", o_out_rsp);
                    end
                end else begin
                    want = pending_colors.pop_front();
                    n_checked++;
                    if (want.red !== o_out_rsp.red || want.green !== o_out_rsp.green ||
                        want.blue !== o_out_rsp.blue) begin
                        n_mismatch++;
                        if (n_mismatch <= 10) begin
                            $display({"color mismatch: expected r=%0d g=%0d b=%0d,",
                                      " got r=%0d g=%0d b=%0d"},
                                     want.red, want.green, want.blue,
                                     o_out_rsp.red, o_out_rsp.green, o_out_rsp.blue);
                        end
                    end
                end
            end
            i_out_ready <= !idle_now();
        end
    end

    // Watchdog: counts cycles with no handshake on either channel.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            wdog <= 0;
        end else begin
            wdog <= wdog + 1;
            if (wdog >= WDOG_MAX) begin
                $display("watchdog expired with %0d colors outstanding", pending_colors.size());
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial begin
        int drain;
        idle_calm   = 0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_req    = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < N_ROWS; i++) begin
            send_flow(rows[i].req, rows[i].has_gold, rows[i].gold);
        end

        for (int i = 0; i < N_RANDOM; i++) begin
            // A stretch in the middle runs with neither side idling.
            idle_calm = (i >= 500 && i < 700);
            send_flow(random_flow(), 1'b0, '0);
        end
        idle_calm = 0;
        i_in_valid <= 1'b0;

        // Let the pipeline drain, then a few more cycles for stray results.
        drain = 0;
        while (pending_colors.size() != 0 && drain < WDOG_MAX * 4) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (DRAIN_CYC) @(posedge i_clk);

        $display("Covered %0d flow vectors (%0d directed) incl. invalid, axes, seam and disc edge.",
                 n_checked, N_ROWS);
        $display("Mismatches: %0d, colors never delivered: %0d",
                 n_mismatch, pending_colors.size());
        if (n_mismatch == 0 && pending_colors.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
